// ===== sv/vmbrf_pkg.sv =====
// Shared types, widths, register offsets and identity constants of the register file.
package vmbrf_pkg;

    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned BYTES_W     = 4;
    localparam int unsigned IN_TDATA_W  = 136;
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned OUT_TUSER_W = 2;

    // Identity words and queue limit
    localparam logic [31:0] MAGIC_WORD      = 32'h7472_6976;
    localparam logic [31:0] MMIO_VERSION    = 32'd2;
    localparam logic [31:0] BLOCK_DEVICE_ID = 32'd2;
    localparam logic [31:0] VENDOR_WORD     = 32'h554d_4551;
    localparam logic [31:0] QUEUE_MAX       = 32'd256;
    localparam logic [3:0]  CAP_READ_BYTES  = 4'd8;

    // Configuration register indexes
    localparam logic CFG_WINDOW_BASE = 1'b0;
    localparam logic CFG_CAPACITY    = 1'b1;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register offsets inside the window
    localparam logic [63:0] OFF_MAGIC        = 64'h000;
    localparam logic [63:0] OFF_VERSION      = 64'h004;
    localparam logic [63:0] OFF_DEVICE_ID    = 64'h008;
    localparam logic [63:0] OFF_VENDOR       = 64'h00c;
    localparam logic [63:0] OFF_DEV_FEAT     = 64'h010;
    localparam logic [63:0] OFF_DEV_FEAT_SEL = 64'h014;
    localparam logic [63:0] OFF_DRV_FEAT     = 64'h020;
    localparam logic [63:0] OFF_DRV_FEAT_SEL = 64'h024;
    localparam logic [63:0] OFF_QUEUE_SEL    = 64'h030;
    localparam logic [63:0] OFF_QUEUE_MAX    = 64'h034;
    localparam logic [63:0] OFF_QUEUE_NUM    = 64'h038;
    localparam logic [63:0] OFF_QUEUE_READY  = 64'h044;
    localparam logic [63:0] OFF_QUEUE_NOTIFY = 64'h050;
    localparam logic [63:0] OFF_IRQ_STATUS   = 64'h060;
    localparam logic [63:0] OFF_IRQ_ACK      = 64'h064;
    localparam logic [63:0] OFF_STATUS       = 64'h070;
    localparam logic [63:0] OFF_DESC_LOW     = 64'h080;
    localparam logic [63:0] OFF_DESC_HIGH    = 64'h084;
    localparam logic [63:0] OFF_AVAIL_LOW    = 64'h090;
    localparam logic [63:0] OFF_AVAIL_HIGH   = 64'h094;
    localparam logic [63:0] OFF_USED_LOW     = 64'h0a0;
    localparam logic [63:0] OFF_USED_HIGH    = 64'h0a4;
    localparam logic [63:0] OFF_CONFIG_GEN   = 64'h0fc;
    localparam logic [63:0] OFF_CONFIG       = 64'h100;

    typedef struct packed {
        logic        kind;
        logic [63:0] bus_address;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
    } item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        queue_request;
        logic        irq_raise;
    } result_t;

endpackage

// ===== sv/vmbrf_in_stage.sv =====
// Input register that holds one accepted bus access for the decode stage.
module vmbrf_in_stage
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [vmbrf_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  advance,
    output vmbrf_pkg::item_t                      item,
    output logic                                  item_valid
);

    logic             valid_reg;
    logic             valid_next;
    vmbrf_pkg::item_t item_reg;
    logic             accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // tdata: bus_address [63:0], access_bytes [67:64], write_data [131:68]
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind         <= s_tuser;
            item_reg.bus_address  <= s_tdata[63:0];
            item_reg.access_bytes <= s_tdata[67:64];
            item_reg.write_data   <= s_tdata[131:68];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== sv/vmbrf_core.sv =====
// Address decode, register state and read mux of the device register window.
module vmbrf_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  vmbrf_pkg::item_t    item,
    input  logic [63:0]         window_base,
    input  logic [63:0]         capacity_sectors,
    output vmbrf_pkg::result_t  result
);

    logic [31:0] status_word_reg,           status_word_next;
    logic [31:0] device_feature_select_reg, device_feature_select_next;
    logic [63:0] driver_feature_bits_reg,   driver_feature_bits_next;
    logic [31:0] driver_feature_select_reg, driver_feature_select_next;
    logic [31:0] queue_select_reg,          queue_select_next;
    logic [15:0] queue_entries_reg,         queue_entries_next;
    logic        queue_enabled_reg,         queue_enabled_next;
    logic [63:0] descriptor_area_reg,       descriptor_area_next;
    logic [63:0] available_area_reg,        available_area_next;
    logic [63:0] used_area_reg,             used_area_next;
    logic [31:0] irq_status_bits_reg,       irq_status_bits_next;

    logic [63:0] offset;
    logic [31:0] v32;
    logic        notify_ok;

    assign offset = item.bus_address - window_base;
    assign v32    = item.write_data[31:0];

    assign notify_ok = (v32 == 32'd0) && queue_enabled_reg
                    && (descriptor_area_reg != 64'd0) && (available_area_reg != 64'd0)
                    && (used_area_reg != 64'd0) && (queue_entries_reg != 16'd0);

    always_comb
    begin
        status_word_next           = status_word_reg;
        device_feature_select_next = device_feature_select_reg;
        driver_feature_bits_next   = driver_feature_bits_reg;
        driver_feature_select_next = driver_feature_select_reg;
        queue_select_next          = queue_select_reg;
        queue_entries_next         = queue_entries_reg;
        queue_enabled_next         = queue_enabled_reg;
        descriptor_area_next       = descriptor_area_reg;
        available_area_next        = available_area_reg;
        used_area_next             = used_area_reg;
        irq_status_bits_next       = irq_status_bits_reg;
        result.read_data           = 64'd0;
        result.queue_request       = 1'b0;
        result.irq_raise           = 1'b0;

        if (item.kind == vmbrf_pkg::KIND_READ)
        begin
            case (offset)
                vmbrf_pkg::OFF_MAGIC:        result.read_data = {32'd0, vmbrf_pkg::MAGIC_WORD};
                vmbrf_pkg::OFF_VERSION:      result.read_data = {32'd0, vmbrf_pkg::MMIO_VERSION};
                vmbrf_pkg::OFF_DEVICE_ID:
                    result.read_data = {32'd0, vmbrf_pkg::BLOCK_DEVICE_ID};
                vmbrf_pkg::OFF_VENDOR:       result.read_data = {32'd0, vmbrf_pkg::VENDOR_WORD};
                vmbrf_pkg::OFF_DEV_FEAT_SEL: result.read_data = {32'd0, device_feature_select_reg};
                vmbrf_pkg::OFF_DRV_FEAT:
                    result.read_data = {32'd0, driver_feature_bits_reg[31:0]};
                vmbrf_pkg::OFF_DRV_FEAT_SEL: result.read_data = {32'd0, driver_feature_select_reg};
                vmbrf_pkg::OFF_QUEUE_SEL:    result.read_data = {32'd0, queue_select_reg};
                vmbrf_pkg::OFF_QUEUE_MAX:    result.read_data = {32'd0, vmbrf_pkg::QUEUE_MAX};
                vmbrf_pkg::OFF_QUEUE_NUM:    result.read_data = {48'd0, queue_entries_reg};
                vmbrf_pkg::OFF_QUEUE_READY:  result.read_data = {63'd0, queue_enabled_reg};
                vmbrf_pkg::OFF_IRQ_STATUS:   result.read_data = {32'd0, irq_status_bits_reg};
                vmbrf_pkg::OFF_STATUS:       result.read_data = {32'd0, status_word_reg};
                vmbrf_pkg::OFF_CONFIG:
                begin
                    // Capacity comes back only on a full 8-byte read
                    if (item.access_bytes == vmbrf_pkg::CAP_READ_BYTES)
                    begin
                        result.read_data = capacity_sectors;
                    end
                end
                default:                     result.read_data = 64'd0;
            endcase
        end
        else
        begin
            case (offset)
                vmbrf_pkg::OFF_DEV_FEAT_SEL: device_feature_select_next = v32;
                vmbrf_pkg::OFF_DRV_FEAT:
                begin
                    if (driver_feature_select_reg == 32'd0)
                    begin
                        driver_feature_bits_next[31:0] = v32;
                    end
                    else
                    begin
                        driver_feature_bits_next[63:32] = v32;
                    end
                end
                vmbrf_pkg::OFF_DRV_FEAT_SEL: driver_feature_select_next = v32;
                vmbrf_pkg::OFF_QUEUE_SEL:    queue_select_next = v32;
                vmbrf_pkg::OFF_QUEUE_NUM:    queue_entries_next = item.write_data[15:0];
                vmbrf_pkg::OFF_QUEUE_READY:  queue_enabled_next = item.write_data[0];
                vmbrf_pkg::OFF_DESC_LOW:     descriptor_area_next[31:0] = v32;
                vmbrf_pkg::OFF_DESC_HIGH:    descriptor_area_next[63:32] = v32;
                vmbrf_pkg::OFF_AVAIL_LOW:    available_area_next[31:0] = v32;
                vmbrf_pkg::OFF_AVAIL_HIGH:   available_area_next[63:32] = v32;
                vmbrf_pkg::OFF_USED_LOW:     used_area_next[31:0] = v32;
                vmbrf_pkg::OFF_USED_HIGH:    used_area_next[63:32] = v32;
                vmbrf_pkg::OFF_QUEUE_NOTIFY:
                begin
                    if (notify_ok)
                    begin
                        result.queue_request    = 1'b1;
                        result.irq_raise        = 1'b1;
                        irq_status_bits_next[0] = 1'b1;
                    end
                end
                vmbrf_pkg::OFF_IRQ_ACK:      irq_status_bits_next = irq_status_bits_reg & ~v32;
                vmbrf_pkg::OFF_STATUS:
                begin
                    status_word_next = v32;
                    // Writing zero resets the queue and drops pending interrupts
                    if (v32 == 32'd0)
                    begin
                        queue_select_next    = 32'd0;
                        queue_entries_next   = 16'd0;
                        queue_enabled_next   = 1'b0;
                        descriptor_area_next = 64'd0;
                        available_area_next  = 64'd0;
                        used_area_next       = 64'd0;
                        irq_status_bits_next = 32'd0;
                    end
                end
                default:
                begin
                    status_word_next = status_word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_word_reg           <= 32'd0;
            device_feature_select_reg <= 32'd0;
            driver_feature_bits_reg   <= 64'd0;
            driver_feature_select_reg <= 32'd0;
            queue_select_reg          <= 32'd0;
            queue_entries_reg         <= 16'd0;
            queue_enabled_reg         <= 1'b0;
            descriptor_area_reg       <= 64'd0;
            available_area_reg        <= 64'd0;
            used_area_reg             <= 64'd0;
            irq_status_bits_reg       <= 32'd0;
        end
        else if (fire)
        begin
            status_word_reg           <= status_word_next;
            device_feature_select_reg <= device_feature_select_next;
            driver_feature_bits_reg   <= driver_feature_bits_next;
            driver_feature_select_reg <= driver_feature_select_next;
            queue_select_reg          <= queue_select_next;
            queue_entries_reg         <= queue_entries_next;
            queue_enabled_reg         <= queue_enabled_next;
            descriptor_area_reg       <= descriptor_area_next;
            available_area_reg        <= available_area_next;
            used_area_reg             <= used_area_next;
            irq_status_bits_reg       <= irq_status_bits_next;
        end
    end

endmodule

// ===== sv/vmbrf_out_stage.sv =====
// Result register that holds one response until the downstream side takes it.
module vmbrf_out_stage
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  vmbrf_pkg::result_t                     result,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [vmbrf_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [vmbrf_pkg::OUT_TUSER_W-1:0]      m_tuser
);

    logic               valid_reg;
    logic               valid_next;
    vmbrf_pkg::result_t result_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.read_data;
    assign m_tuser  = {result_reg.irq_raise, result_reg.queue_request};

endmodule

// ===== sv/virtio_mmio_block_register_file.sv =====
// Register window of a version 2 memory-mapped virtio block device.
//
// Usage:
//   s_* carries bus accesses: s_tuser is the kind (0 read, 1 write), s_tdata
//   packs bus_address, access_bytes and write_data. m_* returns one response
//   per access: m_tdata is read_data, m_tuser holds queue_request and
//   irq_raise. The cfg_* channel writes window_base (index 0) and
//   capacity_sectors (index 1); it is always ready. It must be written only
//   while no access is in flight; the block itself does not enforce this.
//
// An accepted access is captured in the input register; when the result
// register is free or draining, the access is decoded, updates the state and
// loads the result register. The block takes one access per cycle while the
// receiver keeps m_tready high; each access reads the state left by the one
// before it. When the receiver stalls, the response holds and one more access
// waits in the input register before s_tready drops. Reset clears all device
// registers and both configuration words to zero and empties both stages.
module virtio_mmio_block_register_file
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // bus_address [63:0], access_bytes [67:64], write_data [131:68], zero pad
    input  logic [vmbrf_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind [0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // read_data [63:0]
    output logic [vmbrf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // queue_request [0], irq_raise [1]
    output logic [vmbrf_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [63:0]                           cfg_data
);

    logic [63:0]        window_base_reg;
    logic [63:0]        capacity_sectors_reg;
    vmbrf_pkg::item_t   item;
    logic               item_valid;
    logic               advance;
    vmbrf_pkg::result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg      <= 64'd0;
            capacity_sectors_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == vmbrf_pkg::CFG_WINDOW_BASE)
            begin
                window_base_reg <= cfg_data;
            end
            if (cfg_index == vmbrf_pkg::CFG_CAPACITY)
            begin
                capacity_sectors_reg <= cfg_data;
            end
        end
    end

    // Advance the held access whenever the result register is free or draining
    assign advance = item_valid && (!m_tvalid || m_tready);

    vmbrf_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    vmbrf_core u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .item             (item),
        .window_base      (window_base_reg),
        .capacity_sectors (capacity_sectors_reg),
        .result           (result)
    );

    vmbrf_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
